// File: rtl/core/rledc_pkg.sv
// ----------------------------------------------------------------------------
// rledc_pkg
// Shared types, constants and helpers of the decimal-count run-length encoder.
// ----------------------------------------------------------------------------
package rledc_pkg;

  // Decimal digits needed for a 16-bit run length.
  localparam int NDIG = 5;
  // Depth of the queue between the front and back parts.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);
  // Width of the back part's emission position (NDIG down to 0).
  localparam int POS_W = $clog2(NDIG + 1);
  // Upper nibble of an ASCII decimal digit.
  localparam logic [3:0] ASCII_DIGIT_HI = 4'h3;
  // Which run of a queue entry is being emitted.
  localparam logic SEL_A = 1'b0;
  localparam logic SEL_B = 1'b1;

  // Run length as packed BCD digits, digit 0 least significant.
  typedef logic [NDIG-1:0][3:0] bcd_t;

  // One closed run, ready for emission.
  typedef struct packed {
    logic [7:0] run_byte;
    logic       lit;      // Length 1 or 2: emitted as literal copies.
    logic       lit2;     // Length exactly 2.
    bcd_t       digits;   // Decimal length, used when lit is clear.
  } run_t;

  // Everything one input request emits: up to two runs.
  typedef struct packed {
    logic a_valid;  // Run closed because the byte changed or hit the limit.
    run_t run_a;
    logic b_valid;  // Run closed by the end of the stream.
    run_t run_b;
    logic eos;
  } entry_t;

  // Adds one to a BCD count.
  function automatic bcd_t bcd_inc(bcd_t v);
    bcd_t r;
    logic c;
    r = v;
    c = 1'b1;
    for (int i = 0; i < NDIG; i++) begin
      if (c) begin
        if (r[i] == 4'd9) begin
          r[i] = 4'd0;
        end else begin
          r[i] = r[i] + 4'd1;
          c = 1'b0;
        end
      end
    end
    return r;
  endfunction

  // Builds a run record from its byte, binary length and BCD length.
  function automatic run_t make_run(logic [7:0] b, logic [15:0] len, bcd_t d);
    run_t r;
    r.run_byte = b;
    r.lit      = (len <= 16'd2);
    r.lit2     = (len == 16'd2);
    r.digits   = d;
    return r;
  endfunction

  // First emission position of a run: literal copies after the first, or digit count.
  function automatic logic [POS_W-1:0] start_pos(run_t r);
    logic [POS_W-1:0] p;
    p = POS_W'(1);
    if (r.lit) begin
      p = POS_W'(r.lit2);
    end else begin
      for (int i = 1; i < NDIG; i++) begin
        if (r.digits[i] != 4'd0) begin
          p = POS_W'(i + 1);
        end
      end
    end
    return p;
  endfunction

endpackage

// File: rtl/core/rledc_front.sv
// ----------------------------------------------------------------------------
// rledc_front
// Accepts bytes, tracks the open run and queues the runs each byte closes.
// ----------------------------------------------------------------------------
module rledc_front #(
  parameter int MAX_RUN = 65535
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_byte,
  input  logic              in_end_of_stream,
  input  logic              q_full,
  output logic              q_push,
  output rledc_pkg::entry_t q_entry
);

  logic [7:0]     prev_r, prev_nxt;
  logic [15:0]    len_r, len_nxt;
  rledc_pkg::bcd_t bcd_r, bcd_nxt;
  logic           open_r, open_nxt;

  logic            accept;
  logic            extend;
  logic            close;
  logic [7:0]      new_byte;
  logic [15:0]     new_len;
  rledc_pkg::bcd_t new_bcd;

  // A request is taken whenever the queue has room.
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // Classify the byte against the open run.
  always_comb begin
    extend = open_r && (in_byte == prev_r) && (len_r < 16'(MAX_RUN));
    close  = open_r && !extend;
    if (extend) begin
      new_byte = prev_r;
      new_len  = len_r + 16'd1;
      new_bcd  = rledc_pkg::bcd_inc(bcd_r);
    end else begin
      new_byte = in_byte;
      new_len  = 16'd1;
      new_bcd  = rledc_pkg::bcd_t'(1);
    end
  end

  // Queue entry with the closed run and, at stream end, the final run.
  always_comb begin
    q_entry.a_valid = close;
    q_entry.run_a   = rledc_pkg::make_run(prev_r, len_r, bcd_r);
    q_entry.b_valid = in_end_of_stream;
    q_entry.run_b   = rledc_pkg::make_run(new_byte, new_len, new_bcd);
    q_entry.eos     = in_end_of_stream;
    q_push          = accept && (close || in_end_of_stream);
  end

  // Next run state.
  always_comb begin
    prev_nxt = prev_r;
    len_nxt  = len_r;
    bcd_nxt  = bcd_r;
    open_nxt = open_r;
    if (accept) begin
      if (in_end_of_stream) begin
        prev_nxt = 8'd0;
        len_nxt  = 16'd0;
        bcd_nxt  = '0;
        open_nxt = 1'b0;
      end else begin
        prev_nxt = new_byte;
        len_nxt  = new_len;
        bcd_nxt  = new_bcd;
        open_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= 8'd0;
      len_r  <= 16'd0;
      bcd_r  <= '0;
      open_r <= 1'b0;
    end else begin
      prev_r <= prev_nxt;
      len_r  <= len_nxt;
      bcd_r  <= bcd_nxt;
      open_r <= open_nxt;
    end
  end

  // An end-of-stream request always leaves no run open.
  a_eos_closes: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_end_of_stream |=> !open_r)
    else $error("run still open after end of stream");

endmodule

// File: rtl/core/rledc_queue.sv
// ----------------------------------------------------------------------------
// rledc_queue
// Short queue of run entries between the front and back parts.
// ----------------------------------------------------------------------------
module rledc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rledc_pkg::entry_t push_entry,
  output logic              full,
  input  logic              pop,
  output rledc_pkg::entry_t head,
  output logic              empty
);

  rledc_pkg::entry_t                   mem_r [rledc_pkg::QDEPTH];
  logic [rledc_pkg::QPTR_W-1:0] wr_r, wr_nxt;
  logic [rledc_pkg::QPTR_W-1:0] rd_r, rd_nxt;
  logic [rledc_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == rledc_pkg::QCNT_W'(rledc_pkg::QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_r];

  // Pointer and fill count updates.
  always_comb begin
    wr_nxt  = push ? rledc_pkg::QPTR_W'(wr_r + 1'b1) : wr_r;
    rd_nxt  = pop ? rledc_pkg::QPTR_W'(rd_r + 1'b1) : rd_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_entry;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue read while empty");

endmodule

// File: rtl/core/rledc_back.sv
// ----------------------------------------------------------------------------
// rledc_back
// Turns queued runs into output bytes, one byte per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module rledc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  rledc_pkg::entry_t head,
  input  logic              q_empty,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_byte,
  output logic              out_last_of_item,
  output logic              out_stream_done
);

  logic                         started_r, started_nxt;
  logic                         sel_r, sel_nxt;
  logic [rledc_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic                         ov_r, ov_nxt;
  logic [7:0]                   ob_r, ob_nxt;
  logic                         olast_r, olast_nxt;
  logic                         odone_r, odone_nxt;

  logic                         emit;
  logic                         cur_sel;
  rledc_pkg::run_t              cur_run;
  logic [rledc_pkg::POS_W-1:0]  cur_pos;
  logic [rledc_pkg::POS_W-1:0]  dig_idx;
  logic [7:0]                   cur_byte;
  logic                         run_end;
  logic                         entry_end;

  // Output register frees up when empty or when its request is taken.
  assign emit = !q_empty && (!ov_r || !out_stall);

  // Current run and position within the head entry.
  always_comb begin
    if (started_r) begin
      cur_sel = sel_r;
    end else begin
      cur_sel = head.a_valid ? rledc_pkg::SEL_A : rledc_pkg::SEL_B;
    end
    cur_run = (cur_sel == rledc_pkg::SEL_B) ? head.run_b : head.run_a;
    cur_pos = started_r ? pos_r : rledc_pkg::start_pos(cur_run);
    dig_idx = (cur_pos == '0) ? '0 : cur_pos - 1'b1;
    if (cur_run.lit || cur_pos == '0) begin
      cur_byte = cur_run.run_byte;
    end else begin
      cur_byte = {rledc_pkg::ASCII_DIGIT_HI, cur_run.digits[dig_idx]};
    end
    run_end   = (cur_pos == '0);
    entry_end = run_end && ((cur_sel == rledc_pkg::SEL_B) || !head.b_valid);
    q_pop     = emit && entry_end;
  end

  // Sequencer over the runs of the head entry.
  always_comb begin
    started_nxt = started_r;
    sel_nxt     = sel_r;
    pos_nxt     = pos_r;
    if (emit) begin
      if (entry_end) begin
        started_nxt = 1'b0;
      end else if (run_end) begin
        started_nxt = 1'b1;
        sel_nxt     = rledc_pkg::SEL_B;
        pos_nxt     = rledc_pkg::start_pos(head.run_b);
      end else begin
        started_nxt = 1'b1;
        sel_nxt     = cur_sel;
        pos_nxt     = cur_pos - 1'b1;
      end
    end
  end

  // Output register.
  always_comb begin
    ob_nxt    = ob_r;
    olast_nxt = olast_r;
    odone_nxt = odone_r;
    ov_nxt    = ov_r && out_stall;
    if (emit) begin
      ov_nxt    = 1'b1;
      ob_nxt    = cur_byte;
      olast_nxt = entry_end;
      odone_nxt = entry_end && head.eos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= 1'b0;
      sel_r     <= rledc_pkg::SEL_A;
      pos_r     <= '0;
      ov_r      <= 1'b0;
    end else begin
      started_r <= started_nxt;
      sel_r     <= sel_nxt;
      pos_r     <= pos_nxt;
      ov_r      <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ob_r    <= ob_nxt;
    olast_r <= olast_nxt;
    odone_r <= odone_nxt;
  end

  assign out_valid        = ov_r;
  assign out_byte         = ob_r;
  assign out_last_of_item = olast_r;
  assign out_stream_done  = odone_r;

  // A partly emitted entry stays at the head of the queue.
  a_started_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    started_r |-> !q_empty)
    else $error("sequencer active with an empty queue");

  // Finishing an entry always leaves its last byte in the output register.
  a_pop_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_valid && out_last_of_item)
    else $error("entry retired without its last byte");

endmodule

// File: rtl/core/rle_decimal_count_encoder_unit.sv
// ----------------------------------------------------------------------------
// rle_decimal_count_encoder_unit
// Run-length encoder that writes runs of three or more as decimal counts.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake             Payload
//  in_      input      in_valid / in_stall   in_byte, in_end_of_stream
//  out_     output     out_valid / out_stall out_byte, out_last_of_item,
//                                            out_stream_done
//
// The front takes one byte request per cycle while the run queue has room.
// Each byte that closes a run queues one entry of up to 12 output bytes; the back
// emits them one per cycle while the output is not stalled.
// The queue holds four entries; the output bytes are registered.
// Synchronous active-low reset empties the queue and closes any open run.
// A stalled output holds its request; the front stalls only when the queue is full.
// ----------------------------------------------------------------------------
module rle_decimal_count_encoder_unit #(
  parameter int MAX_RUN = 65535
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_stream,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last_of_item,
  output logic       out_stream_done
);

  logic              q_full;
  logic              q_empty;
  logic              q_push;
  logic              q_pop;
  rledc_pkg::entry_t q_in;
  rledc_pkg::entry_t q_head;

  rledc_front #(
    .MAX_RUN(MAX_RUN)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .in_end_of_stream (in_end_of_stream),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_entry          (q_in)
  );

  rledc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty)
  );

  rledc_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (q_head),
    .q_empty          (q_empty),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_last_of_item (out_last_of_item),
    .out_stream_done  (out_stream_done)
  );

endmodule

// File: test/rle_decimal_count_encoder_unit_tb.sv
// ----------------------------------------------------------------------------
// rle_decimal_count_encoder_unit_tb
// Self-checking bench for the decimal-count run-length encoder. Byte streams
// go in through the valid/stall input channel. A cycle-free model of the
// encoder predicts every output byte, and each accepted output is compared
// with the oldest prediction. Directed streams cover literal runs, counted
// runs, dash bytes at a stream start and a three-digit count. Random streams
// follow, with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module rle_decimal_count_encoder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_RUN = 65535;
  localparam int CYCLE_LIMIT = 2_000_000;
  // Output register plus queue stages, with margin.
  localparam int SETTLE_CYCLES = 24;
  localparam int RANDOM_ITEMS = 260;
  localparam logic [7:0] CHAR_ZERO = "0";
  localparam logic [7:0] CHAR_DASH = "-";

  // One predicted output byte.
  typedef struct packed {
    logic [7:0] code;
    logic       last_of_item;
    logic       stream_done;
  } enc_byte_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       in_end_of_stream = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_last_of_item;
  logic       out_stream_done;

  // Encoder model state.
  logic [7:0] model_prev_byte = 8'h00;
  int         model_run_len = 0;
  bit         model_run_open = 1'b0;

  enc_byte_t   expected_bytes[$];
  enc_byte_t   oldest_byte;
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          items_sent = 0;
  int          burst_left = 0;
  bit          bursty = 1'b1;
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_left = 0;
  int          stall_phase = 0;

  rle_decimal_count_encoder_unit #(
    .MAX_RUN(MAX_RUN)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .in_end_of_stream (in_end_of_stream),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_last_of_item (out_last_of_item),
    .out_stream_done  (out_stream_done)
  );

  // Clock: 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d bytes still expected", $time, expected_bytes.size());
      $display("rle_decimal_count_encoder_unit_tb: done, errors");
      $finish;
    end
  end

  // Receiver stall pattern: modes of random length, one of them never stalls.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    stall_phase++;
    case (stall_mode)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
      STALL_PERIODIC: out_stall <= stall_phase[2];
      default:        out_stall <= 1'b0;
    endcase
  end

  // Compare each accepted output byte with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected output: expected none, got byte %02h last %b done %b",
                 $time, out_byte, out_last_of_item, out_stream_done);
        mismatch_count++;
      end else begin
        oldest_byte = expected_bytes.pop_front();
        if (out_byte !== oldest_byte.code) begin
          $display("%0t: out_byte expected %02h, got %02h", $time, oldest_byte.code, out_byte);
          mismatch_count++;
        end
        if (out_last_of_item !== oldest_byte.last_of_item) begin
          $display("%0t: out_last_of_item expected %b, got %b", $time,
                   oldest_byte.last_of_item, out_last_of_item);
          mismatch_count++;
        end
        if (out_stream_done !== oldest_byte.stream_done) begin
          $display("%0t: out_stream_done expected %b, got %b", $time,
                   oldest_byte.stream_done, out_stream_done);
          mismatch_count++;
        end
      end
    end
  end

  // Appends one predicted byte, with both flags clear, to the expected queue.
  function automatic void add_expected(logic [7:0] code);
    enc_byte_t e;
    e.code         = code;
    e.last_of_item = 1'b0;
    e.stream_done  = 1'b0;
    expected_bytes.insert(expected_bytes.size(), e);
  endfunction

  // Queues the encoding of one closed run: literal copies or count then byte.
  function automatic void queue_run_code(logic [7:0] run_byte, int run_len);
    int digits[5];
    int ndig;
    int rest;
    ndig = 0;
    rest = run_len;
    if (run_len <= 2) begin
      for (int i = 0; i < run_len; i++) begin
        add_expected(run_byte);
      end
    end else begin
      while (rest != 0) begin
        digits[ndig] = rest % 10;
        rest = rest / 10;
        ndig++;
      end
      for (int i = ndig - 1; i >= 0; i--) begin
        add_expected(CHAR_ZERO + 8'(digits[i]));
      end
      add_expected(run_byte);
    end
  endfunction

  // Advances the encoder model by one accepted byte request.
  function automatic void encode_step(logic [7:0] b, logic eos);
    int first;
    int tail;
    first = expected_bytes.size();
    if (model_run_open && b == model_prev_byte && model_run_len < MAX_RUN) begin
      model_run_len++;
    end else begin
      if (model_run_open) begin
        queue_run_code(model_prev_byte, model_run_len);
      end
      model_prev_byte = b;
      model_run_len = 1;
      model_run_open = 1'b1;
    end
    if (eos) begin
      queue_run_code(model_prev_byte, model_run_len);
      model_prev_byte = 8'h00;
      model_run_len = 0;
      model_run_open = 1'b0;
    end
    // Flag the final byte caused by this request.
    if (expected_bytes.size() > first) begin
      tail = expected_bytes.size() - 1;
      expected_bytes[tail].last_of_item = 1'b1;
      expected_bytes[tail].stream_done = eos;
    end
  endfunction

  // Sends one byte request, with a random gap at the start of each burst.
  task automatic send_byte(input logic [7:0] b, input logic eos);
    int gap;
    if (bursty && burst_left == 0) begin
      gap = $urandom_range(0, 8);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0) begin
      burst_left--;
    end
    in_valid <= 1'b1;
    in_byte <= b;
    in_end_of_stream <= eos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    encode_step(b, eos);
    items_sent++;
  endtask

  // Sends a run of identical bytes; eos marks only the final one.
  task automatic send_run(input logic [7:0] b, input int len, input logic eos);
    for (int i = 0; i < len; i++) begin
      send_byte(b, eos && (i == len - 1));
    end
  endtask

  // Holds the sender off until every predicted byte has come out.
  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  // Literal runs, extreme bytes, and dash or zero bytes at a stream start.
  task automatic test_literal_runs();
    // A zero byte right after reset must open a run, not extend one.
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    // A zero byte again at the start of the next stream.
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    // Leading dashes are ordinary bytes.
    send_byte(CHAR_DASH, 1'b0);
    send_byte(CHAR_DASH, 1'b0);
    send_byte("x", 1'b1);
    send_byte(CHAR_DASH, 1'b1);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'hAA, 1'b1);
    wait_all_results();
  endtask

  // Shortest counted run and a two-digit count.
  task automatic test_counted_runs();
    send_run("A", 3, 1'b1);
    send_run(8'h80, 10, 1'b0);
    send_byte(8'h7F, 1'b1);
    wait_all_results();
  endtask

  // A back-to-back three-digit count with a zero digit inside.
  task automatic test_long_run();
    bursty = 1'b0;
    send_run(8'hC3, 105, 1'b0);
    send_byte(8'h3C, 1'b1);
    bursty = 1'b1;
    wait_all_results();
  endtask

  // Random streams: mostly runs on a small alphabet, some noisy streams.
  task automatic test_random_streams();
    int nruns;
    int len;
    int pick;
    bit noisy;
    logic [7:0] b;
    logic eos;
    int start_items;
    start_items = items_sent;
    while (items_sent - start_items < RANDOM_ITEMS) begin
      noisy = ($urandom_range(0, 9) == 0);
      nruns = $urandom_range(1, 8);
      for (int r = 0; r < nruns; r++) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) len = 1;
        else if (pick < 60) len = 2;
        else if (pick < 85) len = $urandom_range(3, 9);
        else if (pick < 97) len = $urandom_range(10, 40);
        else len = $urandom_range(90, 130);
        case ($urandom_range(0, 3))
          0:       b = CHAR_DASH;
          1:       b = 8'(($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00);
          2:       b = 8'($urandom_range(0, 255));
          default: b = 8'("a" + $urandom_range(0, 2));
        endcase
        for (int i = 0; i < len; i++) begin
          eos = (r == nruns - 1) && (i == len - 1);
          if (noisy) begin
            // Stray stream ends and random bytes break the runs up.
            eos = eos || ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 3) == 0) begin
              b = 8'($urandom_range(0, 255));
            end
          end
          send_byte(b, eos);
        end
      end
      if ($urandom_range(0, 7) == 0) begin
        wait_all_results();
      end
    end
    wait_all_results();
  endtask

  // Test sequence.
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_literal_runs();
    test_counted_runs();
    test_long_run();
    test_random_streams();
    wait_all_results();
    if (mismatch_count == 0) begin
      $display("rle_decimal_count_encoder_unit_tb: done, clean");
    end else begin
      $display("rle_decimal_count_encoder_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
